@@ hw/rtl/rmh_pkg.sv @@
// Shared constants and types for the running median block.
// No dependencies.
package rmh_pkg;
    localparam int HEAP_DEPTH = 512;
    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);

    typedef logic [AW-1:0] addr_t;
    typedef logic [CW-1:0] cnt_t;
    typedef logic signed [31:0] word_t;
    typedef logic signed [32:0] med_t;

    typedef struct packed {
        logic  op_push;
        logic  op_repl;
        word_t value;
        cnt_t  count;
    } heap_cmd_t;
endpackage

@@ hw/rtl/running_median_two_heaps_top.sv @@
// Running median top level: two RAM-backed heaps and a sequencer.
// A push sifts up; a replace-top sifts down and its old top is then pushed into the other
// heap; a drop leaves both heaps alone. One request in flight; the next is accepted once
// the result has loaded, later only while m_tready holds off the previous result.
// Reset: asynchronous active-low rst_n empties both heaps (counts only; RAM not cleared).
// Depends on rmh_pkg, rmh_heap, rmh_ctrl.
module running_median_two_heaps_top
    import rmh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [32:0] median_doubled, [43:33] sample_count, zero pad
    output logic        m_tuser    // dropped
);
    heap_cmd_t lo_cmd, up_cmd;
    logic lo_start, up_start, lo_busy, up_busy;
    word_t lo_top, up_top, lo_old, up_old;
    med_t med;
    logic [10:0] cnt;

    rmh_heap u_lo (.clk, .rst_n, .is_max(1'b1), .start(lo_start), .cmd(lo_cmd),
        .busy(lo_busy), .top(lo_top), .old_top(lo_old));
    rmh_heap u_up (.clk, .rst_n, .is_max(1'b0), .start(up_start), .cmd(up_cmd),
        .busy(up_busy), .top(up_top), .old_top(up_old));

    rmh_ctrl u_ctrl (.clk, .rst_n, .in_valid(s_tvalid), .in_ready(s_tready),
        .in_sample(s_tdata), .out_valid(m_tvalid), .out_ready(m_tready),
        .out_med(med), .out_cnt(cnt), .out_drop(m_tuser),
        .lo_start, .lo_cmd, .lo_busy, .lo_top, .lo_old,
        .up_start, .up_cmd, .up_busy, .up_top, .up_old);

    assign m_tdata = {4'b0, cnt, med};
endmodule

@@ hw/rtl/rmh_heap.sv @@
// One heap held in a synchronous RAM; push (sift up) and replace-top (sift down).
// Depends on rmh_pkg. The top entry is mirrored in a register.
module rmh_heap
    import rmh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      is_max,
    input  logic      start,
    input  heap_cmd_t cmd,
    output logic      busy,
    output word_t     top,
    output word_t     old_top
);
    typedef enum logic [2:0] {S_IDLE, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_RD2, S_DN_CMP} st_t;

    word_t mem [HEAP_DEPTH];
    word_t rd_data_reg;
    addr_t rd_addr;
    logic  we;
    addr_t wa;
    word_t wd;

    st_t   st_reg;
    addr_t i_reg;
    word_t v_reg;
    word_t l_reg;
    cnt_t  cnt_reg;
    word_t top_reg;
    word_t old_reg;

    function automatic logic above(word_t a, word_t b, logic mx);
        return mx ? (a > b) : (a < b);
    endfunction

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    logic [AW:0] lidx;
    logic [AW:0] ridx;
    addr_t       par;
    logic        up_swap;
    logic        dn_has_l;
    logic        dn_use_r;
    word_t       dn_bv;
    logic        dn_swap;
    assign lidx = {i_reg, 1'b1};
    assign ridx = {i_reg, 1'b0} + (AW+1)'(2);
    assign par  = (i_reg - addr_t'(1)) >> 1;

    assign up_swap  = (i_reg != '0) && above(v_reg, rd_data_reg, is_max);
    assign dn_has_l = ({1'b0, lidx} < (AW+2)'(cnt_reg));
    assign dn_use_r = ({1'b0, ridx} < (AW+2)'(cnt_reg)) && above(rd_data_reg, l_reg, is_max);
    assign dn_bv    = dn_use_r ? rd_data_reg : l_reg;
    assign dn_swap  = dn_has_l && above(dn_bv, v_reg, is_max);

    always_comb
    begin
        rd_addr = par;
        we = 1'b0;
        wa = i_reg;
        wd = v_reg;
        case (st_reg)
            S_IDLE:
            begin
                rd_addr = par;
            end
            S_UP_RD:
            begin
                rd_addr = par;
            end
            S_UP_CMP:
            begin
                we = 1'b1;
                wa = i_reg;
                wd = up_swap ? rd_data_reg : v_reg;
            end
            S_DN_RD:
            begin
                rd_addr = lidx[AW-1:0];
            end
            S_DN_RD2:
            begin
                rd_addr = ridx[AW-1:0];
            end
            S_DN_CMP:
            begin
                we = 1'b1;
                wd = dn_swap ? dn_bv : v_reg;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_IDLE;
            i_reg   <= '0;
            v_reg   <= '0;
            l_reg   <= '0;
            cnt_reg <= '0;
            top_reg <= '0;
            old_reg <= '0;
        end
        else
        begin
            case (st_reg)
                S_IDLE:
                begin
                    if (start && cmd.op_push)
                    begin
                        i_reg   <= cmd.count[AW-1:0];
                        v_reg   <= cmd.value;
                        cnt_reg <= cmd.count;
                        if (cmd.count == '0)
                        begin
                            top_reg <= cmd.value;
                            st_reg  <= S_UP_CMP;
                        end
                        else
                        begin
                            st_reg <= S_UP_RD;
                        end
                    end
                    else if (start && cmd.op_repl)
                    begin
                        i_reg   <= '0;
                        v_reg   <= cmd.value;
                        cnt_reg <= cmd.count;
                        old_reg <= top_reg;
                        top_reg <= cmd.value;
                        st_reg  <= S_DN_RD;
                    end
                end
                S_UP_RD:
                begin
                    st_reg <= S_UP_CMP;
                end
                S_UP_CMP:
                begin
                    if (up_swap)
                    begin
                        i_reg <= par;
                        if (par == '0)
                        begin
                            top_reg <= v_reg;
                            st_reg  <= S_UP_CMP;
                        end
                        else
                        begin
                            st_reg <= S_UP_RD;
                        end
                    end
                    else
                    begin
                        st_reg <= S_IDLE;
                    end
                end
                S_DN_RD:
                begin
                    if ({1'b0, lidx} >= (AW+2)'(cnt_reg))
                    begin
                        st_reg <= S_DN_CMP;
                    end
                    else
                    begin
                        st_reg <= S_DN_RD2;
                    end
                end
                S_DN_RD2:
                begin
                    l_reg  <= rd_data_reg;
                    st_reg <= S_DN_CMP;
                end
                S_DN_CMP:
                begin
                    if (dn_swap)
                    begin
                        if (i_reg == '0)
                        begin
                            top_reg <= dn_bv;
                        end
                        i_reg  <= dn_use_r ? ridx[AW-1:0] : lidx[AW-1:0];
                        st_reg <= S_DN_RD;
                    end
                    else
                    begin
                        st_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy    = (st_reg != S_IDLE);
    assign top     = top_reg;
    assign old_top = old_reg;
endmodule

@@ hw/rtl/rmh_ctrl.sv @@
// Sequencer: takes a sample, picks the heap operations, reports the median.
// Depends on rmh_pkg.
module rmh_ctrl
    import rmh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  word_t     in_sample,
    output logic      out_valid,
    input  logic      out_ready,
    output med_t      out_med,
    output logic [10:0] out_cnt,
    output logic      out_drop,
    output logic      lo_start,
    output heap_cmd_t lo_cmd,
    input  logic      lo_busy,
    input  word_t     lo_top,
    input  word_t     lo_old,
    output logic      up_start,
    output heap_cmd_t up_cmd,
    input  logic      up_busy,
    input  word_t     up_top,
    input  word_t     up_old
);
    typedef enum logic [2:0] {C_IDLE, C_GO, C_W1, C_MOVE, C_OUT} st_t;

    st_t         st_reg, st_next;
    word_t       s_reg, s_next;
    cnt_t        lc_reg, lc_next;
    cnt_t        uc_reg, uc_next;
    logic        drop_reg, drop_next;
    logic        mv_lo_reg, mv_lo_next;
    logic        vld_reg, vld_next;
    med_t        med_reg, med_next;
    logic [10:0] cnt_reg, cnt_next;
    logic        odrop_reg, odrop_next;
    logic        lo_start_reg, lo_start_next;
    logic        up_start_reg, up_start_next;
    heap_cmd_t   lo_cmd_reg, lo_cmd_next;
    heap_cmd_t   up_cmd_reg, up_cmd_next;

    med_t lo_e;
    med_t up_e;
    med_t m2;
    med_t s2;
    assign lo_e = (lc_reg != '0) ? med_t'(lo_top) : '0;
    assign up_e = (uc_reg != '0) ? med_t'(up_top) : '0;
    assign m2 = (lc_reg == uc_reg) ? lo_e + up_e :
                (lc_reg < uc_reg) ? (up_e <<< 1) : (lo_e <<< 1);
    assign s2 = med_t'(s_reg) <<< 1;

    logic busy_any;
    assign busy_any = lo_busy || up_busy || lo_start_reg || up_start_reg;

    always_comb
    begin
        st_next       = st_reg;
        s_next        = s_reg;
        lc_next       = lc_reg;
        uc_next       = uc_reg;
        drop_next     = drop_reg;
        mv_lo_next    = mv_lo_reg;
        vld_next      = vld_reg;
        med_next      = med_reg;
        cnt_next      = cnt_reg;
        odrop_next    = odrop_reg;
        lo_start_next = 1'b0;
        up_start_next = 1'b0;
        lo_cmd_next   = lo_cmd_reg;
        up_cmd_next   = up_cmd_reg;
        if (vld_reg && out_ready)
        begin
            vld_next = 1'b0;
        end
        case (st_reg)
            C_IDLE:
            begin
                if (in_valid)
                begin
                    s_next  = in_sample;
                    st_next = C_GO;
                end
            end
            C_GO:
            begin
                drop_next   = 1'b0;
                mv_lo_next  = 1'b0;
                st_next     = C_W1;
                lo_cmd_next = '{op_push: 1'b1, op_repl: 1'b0, value: s_reg, count: lc_reg};
                up_cmd_next = '{op_push: 1'b1, op_repl: 1'b0, value: s_reg, count: uc_reg};
                if (lc_reg == cnt_t'(HEAP_DEPTH) && uc_reg == cnt_t'(HEAP_DEPTH))
                begin
                    drop_next = 1'b1;
                    st_next   = C_OUT;
                end
                else if (lc_reg == '0 && uc_reg == '0)
                begin
                    lo_start_next = 1'b1;
                    lc_next       = lc_reg + cnt_t'(1);
                end
                else if (lc_reg == uc_reg)
                begin
                    if (s2 <= m2)
                    begin
                        lo_start_next = 1'b1;
                        lc_next       = lc_reg + cnt_t'(1);
                    end
                    else
                    begin
                        up_start_next = 1'b1;
                        uc_next       = uc_reg + cnt_t'(1);
                    end
                end
                else if (lc_reg < uc_reg)
                begin
                    if (s2 > m2)
                    begin
                        up_cmd_next   = '{op_push: 1'b0, op_repl: 1'b1, value: s_reg,
                                          count: uc_reg};
                        up_start_next = 1'b1;
                        mv_lo_next    = 1'b1;
                        st_next       = C_MOVE;
                    end
                    else
                    begin
                        lo_start_next = 1'b1;
                        lc_next       = lc_reg + cnt_t'(1);
                    end
                end
                else
                begin
                    if (s2 < m2)
                    begin
                        lo_cmd_next   = '{op_push: 1'b0, op_repl: 1'b1, value: s_reg,
                                          count: lc_reg};
                        lo_start_next = 1'b1;
                        st_next       = C_MOVE;
                    end
                    else
                    begin
                        up_start_next = 1'b1;
                        uc_next       = uc_reg + cnt_t'(1);
                    end
                end
            end
            C_MOVE:
            begin
                if (!busy_any)
                begin
                    if (mv_lo_reg)
                    begin
                        lo_cmd_next   = '{op_push: 1'b1, op_repl: 1'b0, value: up_old,
                                          count: lc_reg};
                        lo_start_next = 1'b1;
                        lc_next       = lc_reg + cnt_t'(1);
                    end
                    else
                    begin
                        up_cmd_next   = '{op_push: 1'b1, op_repl: 1'b0, value: lo_old,
                                          count: uc_reg};
                        up_start_next = 1'b1;
                        uc_next       = uc_reg + cnt_t'(1);
                    end
                    st_next = C_W1;
                end
            end
            C_W1:
            begin
                if (!busy_any)
                begin
                    st_next = C_OUT;
                end
            end
            C_OUT:
            begin
                if (!vld_reg || out_ready)
                begin
                    vld_next   = 1'b1;
                    med_next   = m2;
                    cnt_next   = 11'(lc_reg) + 11'(uc_reg);
                    odrop_next = drop_reg;
                    st_next    = C_IDLE;
                end
            end
            default:
            begin
                st_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= C_IDLE;
            s_reg        <= '0;
            lc_reg       <= '0;
            uc_reg       <= '0;
            drop_reg     <= 1'b0;
            mv_lo_reg    <= 1'b0;
            vld_reg      <= 1'b0;
            med_reg      <= '0;
            cnt_reg      <= '0;
            odrop_reg    <= 1'b0;
            lo_start_reg <= 1'b0;
            up_start_reg <= 1'b0;
            lo_cmd_reg   <= '0;
            up_cmd_reg   <= '0;
        end
        else
        begin
            st_reg       <= st_next;
            s_reg        <= s_next;
            lc_reg       <= lc_next;
            uc_reg       <= uc_next;
            drop_reg     <= drop_next;
            mv_lo_reg    <= mv_lo_next;
            vld_reg      <= vld_next;
            med_reg      <= med_next;
            cnt_reg      <= cnt_next;
            odrop_reg    <= odrop_next;
            lo_start_reg <= lo_start_next;
            up_start_reg <= up_start_next;
            lo_cmd_reg   <= lo_cmd_next;
            up_cmd_reg   <= up_cmd_next;
        end
    end

    assign in_ready  = (st_reg == C_IDLE);
    assign out_valid = vld_reg;
    assign out_med   = med_reg;
    assign out_cnt   = cnt_reg;
    assign out_drop  = odrop_reg;
    assign lo_start  = lo_start_reg;
    assign up_start  = up_start_reg;
    assign lo_cmd    = lo_cmd_reg;
    assign up_cmd    = up_cmd_reg;
endmodule

@@ test/running_median_two_heaps_top_tb.sv @@
// Testbench for running_median_two_heaps_top: drives samples on the stream input and
// checks median, count and drop flag against an in-bench two-heap predictor.
// Depends on rmh_pkg and the running_median_two_heaps_top RTL.
`timescale 1ns / 100ps
module running_median_two_heaps_top_tb
    import rmh_pkg::*;
();

    localparam int N_DIR = 12;
    localparam int N_RAND = 1400;
    localparam longint CYCLE_LIMIT = 600000;

    typedef struct {
        logic [32:0] med2;
        logic [10:0] cnt;
        logic        drop;
    } median_res_t;

    typedef struct {
        logic [31:0] sample;
        logic        known;
        logic [32:0] med2;
        logic [10:0] cnt;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tuser;

    word_t lo_heap [HEAP_DEPTH];
    word_t hi_heap [HEAP_DEPTH];
    int    lo_cnt;
    int    hi_cnt;
    median_res_t median_q[$];
    logic [32:0] dir_med_q[$];
    logic [10:0] dir_cnt_q[$];
    bit          dir_known_q[$];
    bit          failed;
    longint      cycles;

    running_median_two_heaps_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic bit ranks_above(word_t a, word_t b, bit is_max);
        return is_max ? (a > b) : (a < b);
    endfunction

    task automatic heap_insert(ref word_t h[HEAP_DEPTH], ref int n, input word_t v,
                               input bit is_max);
        int i;
        int p;
        word_t t;
        if (n >= HEAP_DEPTH) return;
        i = n;
        h[i] = v;
        n = n + 1;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (!ranks_above(h[i], h[p], is_max)) break;
            t = h[p]; h[p] = h[i]; h[i] = t;
            i = p;
        end
    endtask

    task automatic heap_swap_top(ref word_t h[HEAP_DEPTH], input int n, input word_t v,
                                 input bit is_max, output word_t old);
        int i;
        int l;
        int r;
        int best;
        word_t t;
        old = h[0];
        h[0] = v;
        i = 0;
        forever
        begin
            l = 2 * i + 1;
            r = l + 1;
            best = i;
            if (l < n && ranks_above(h[l], h[best], is_max)) best = l;
            if (r < n && ranks_above(h[r], h[best], is_max)) best = r;
            if (best == i) break;
            t = h[best]; h[best] = h[i]; h[i] = t;
            i = best;
        end
    endtask

    function automatic logic signed [33:0] median_x2();
        logic signed [33:0] a;
        logic signed [33:0] b;
        a = (lo_cnt > 0) ? 34'(lo_heap[0]) : 34'sd0;
        b = (hi_cnt > 0) ? 34'(hi_heap[0]) : 34'sd0;
        if (lo_cnt == hi_cnt) return a + b;
        if (lo_cnt < hi_cnt) return 2 * b;
        return 2 * a;
    endfunction

    task automatic predict_median(input word_t s);
        median_res_t r;
        logic signed [33:0] s2;
        logic signed [33:0] m;
        word_t t;
        r.drop = 1'b0;
        if (lo_cnt >= HEAP_DEPTH && hi_cnt >= HEAP_DEPTH)
            r.drop = 1'b1;
        else if (lo_cnt == 0 && hi_cnt == 0)
            heap_insert(lo_heap, lo_cnt, s, 1'b1);
        else
        begin
            s2 = 2 * 34'(s);
            m = median_x2();
            if (lo_cnt == hi_cnt)
            begin
                if (s2 <= m) heap_insert(lo_heap, lo_cnt, s, 1'b1);
                else heap_insert(hi_heap, hi_cnt, s, 1'b0);
            end
            else if (lo_cnt < hi_cnt)
            begin
                if (s2 > m)
                begin
                    heap_swap_top(hi_heap, hi_cnt, s, 1'b0, t);
                    heap_insert(lo_heap, lo_cnt, t, 1'b1);
                end
                else heap_insert(lo_heap, lo_cnt, s, 1'b1);
            end
            else
            begin
                if (s2 < m)
                begin
                    heap_swap_top(lo_heap, lo_cnt, s, 1'b1, t);
                    heap_insert(hi_heap, hi_cnt, t, 1'b0);
                end
                else heap_insert(hi_heap, hi_cnt, s, 1'b0);
            end
        end
        m = median_x2();
        r.med2 = m[32:0];
        r.cnt = 11'(lo_cnt + hi_cnt);
        median_q.push_back(r);
    endtask

    // sender: bursts with random gaps
    task automatic send_sample(input logic [31:0] v);
        s_tvalid <= 1'b1;
        s_tdata <= v;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_median(v);
    endtask

    int burst_left;
    task automatic maybe_gap();
        int g;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 20);
        g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] rand_sample(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 40)) - 20);
            2: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 3)
                                           : 32'h80000000 + $urandom_range(0, 3);
            default: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
        endcase
    endfunction

    // receiver stall pattern and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ((cycles % 97) < 60) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end

    always @(posedge clk)
    begin
        median_res_t e;
        logic [32:0] dm;
        logic [10:0] dc;
        bit dk;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (median_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, m_tdata);
                failed = 1'b1;
            end
            else
            begin
                e = median_q.pop_front();
                if (dir_known_q.size() > 0)
                begin
                    dk = dir_known_q.pop_front();
                    dm = dir_med_q.pop_front();
                    dc = dir_cnt_q.pop_front();
                    if (dk && dm !== m_tdata[32:0])
                    begin
                        $display("%0t: table median exp %h got %h", $time, dm, m_tdata[32:0]);
                        failed = 1'b1;
                    end
                    if (dk && dc !== m_tdata[43:33])
                    begin
                        $display("%0t: table count exp %0d got %0d", $time, dc,
                                 m_tdata[43:33]);
                        failed = 1'b1;
                    end
                end
                if (m_tdata[32:0] !== e.med2)
                begin
                    $display("%0t: median exp %h got %h", $time, e.med2, m_tdata[32:0]);
                    failed = 1'b1;
                end
                if (m_tdata[43:33] !== e.cnt)
                begin
                    $display("%0t: count exp %0d got %0d", $time, e.cnt, m_tdata[43:33]);
                    failed = 1'b1;
                end
                if (m_tdata[47:44] !== 4'd0)
                begin
                    $display("%0t: pad exp 0 got %h", $time, m_tdata[47:44]);
                    failed = 1'b1;
                end
                if (m_tuser !== e.drop)
                begin
                    $display("%0t: dropped exp %b got %b", $time, e.drop, m_tuser);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    dir_row_t dir_tab [N_DIR] = '{
        '{32'h00000000, 1'b1, 33'h000000000, 11'd1},
        '{32'h7fffffff, 1'b1, 33'h07fffffff, 11'd2},
        '{32'h80000000, 1'b1, 33'h000000000, 11'd3},
        '{32'h80000000, 1'b1, 33'h180000000, 11'd4},
        '{32'h80000000, 1'b1, 33'h100000000, 11'd5},
        '{32'h7fffffff, 1'b0, 33'h0, 11'd0},
        '{32'h7fffffff, 1'b0, 33'h0, 11'd0},
        '{32'h7fffffff, 1'b0, 33'h0, 11'd0},
        '{32'h00000005, 1'b0, 33'h0, 11'd0},
        '{32'hfffffffb, 1'b0, 33'h0, 11'd0},
        '{32'h00000005, 1'b0, 33'h0, 11'd0},
        '{32'h55555555, 1'b0, 33'h0, 11'd0}
    };

    initial
    begin
        int mode;
        int k;
        failed = 1'b0;
        cycles = 0;
        lo_cnt = 0;
        hi_cnt = 0;
        burst_left = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIR; i++)
        begin
            dir_known_q.push_back(dir_tab[i].known);
            dir_med_q.push_back(dir_tab[i].med2);
            dir_cnt_q.push_back(dir_tab[i].cnt);
            send_sample(dir_tab[i].sample);
            maybe_gap();
        end

        // mostly mixed values; a long stretch to fill the store and exercise drops
        k = 0;
        while (k < N_RAND || (lo_cnt < HEAP_DEPTH || hi_cnt < HEAP_DEPTH) || k < N_RAND + 40)
        begin
            mode = $urandom_range(0, 5);
            send_sample(rand_sample(mode > 3 ? 0 : mode));
            maybe_gap();
            k++;
        end
        s_tvalid <= 1'b0;

        while (median_q.size() > 0) @(posedge clk);
        repeat (80) @(posedge clk);
        if (!failed)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
